### design/fslt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslt_pkg
// Shared types and constants for the failed source lockout table.
// ----------------------------------------------------------------------------
package fslt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W  = 32;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;
  localparam int OUTCOME_W = 3;
  localparam int INDEX_OUT_W = 6;
  localparam int UNIQUE_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [CNT_W-1:0]  LOCK_LIMIT_RESET = 16'd3;
  localparam logic [TIME_W-1:0] LOCK_SPAN_RESET  = 32'd300;

  localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_SPAN  = 1'd1;

  localparam logic [OUTCOME_W-1:0] OC_IGNORED   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_COUNTED   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_NEW_BLOCK = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_BLOCKED   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_FULL      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic              match_en;
    logic [KEY_W-1:0]  key;
    logic [USED_W-1:0] used;
  } cell_query_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] lock_end;
  } cell_wr_t;

  // passed cell to cell, or-combined
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] lock_end;
  } cell_rd_t;

endpackage

### design/fslt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslt_cell
// One table slot: key, failure count and blocked-until time, local match.
// ----------------------------------------------------------------------------
module fslt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fslt_pkg::IDX_W-1:0] cell_idx,
  input  fslt_pkg::cell_query_t     query,
  input  fslt_pkg::cell_wr_t        wr,
  input  fslt_pkg::cell_rd_t        rd_in,
  output fslt_pkg::cell_rd_t        rd_out,
  output logic                      hit
);

  logic [fslt_pkg::KEY_W-1:0]  key;
  logic [fslt_pkg::CNT_W-1:0]  count;
  logic [fslt_pkg::TIME_W-1:0] lock_end;
  logic                        occupied;

  // slots below the fill count hold live entries
  assign occupied = fslt_pkg::USED_W'(cell_idx) < query.used;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (query.match_en) begin
      hit <= occupied && (key == query.key);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      key      <= wr.key;
      count    <= wr.count;
      lock_end <= wr.lock_end;
    end
  end

  always_comb begin
    rd_out.hit      = rd_in.hit | hit;
    rd_out.idx      = rd_in.idx      | (hit ? cell_idx : '0);
    rd_out.count    = rd_in.count    | (hit ? count : '0);
    rd_out.lock_end = rd_in.lock_end | (hit ? lock_end : '0);
  end

endmodule

### design/fslt_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslt_array
// Row of table cells; the matching slot's contents ride down the chain.
// ----------------------------------------------------------------------------
module fslt_array (
  input  logic                  clk,
  input  logic                  rst,
  input  fslt_pkg::cell_query_t query,
  input  fslt_pkg::cell_wr_t    wr,
  output fslt_pkg::cell_rd_t    rd
);

  fslt_pkg::cell_rd_t                   chain [fslt_pkg::TABLE_ENTRIES+1];
  logic [fslt_pkg::TABLE_ENTRIES-1:0]   hit_vec;

  assign chain[0] = '0;

  for (genvar i = 0; i < fslt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    fslt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (fslt_pkg::IDX_W'(i)),
      .query    (query),
      .wr       (wr),
      .rd_in    (chain[i]),
      .rd_out   (chain[i+1]),
      .hit      (hit_vec[i])
    );
  end

  assign rd = chain[fslt_pkg::TABLE_ENTRIES];

  // keys are unique among live slots, so at most one cell matches
  a_single_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one table cell matched");

endmodule

### design/failed_source_lockout_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failed_source_lockout_table
// Per-source failure counter with lockout, one row of table cells.
//
//   port group   dir  handshake          contents
//   in           in   in_valid/in_ready  source_addr, is_failure, now_time, last_event
//   out          out  out_valid/out_ready outcome, entry_index, fail_total,
//                                         unique_count, last_result
//   cfg          in   cfg_we             cfg_index, cfg_data
//
// Each word passes through ST_MATCH, where every cell compares its key, and
// then ST_UPDATE, which merges the matching cell down the row and updates that slot.
// A new word is taken in the same cycle the previous update finishes.
// Reset clears the fill count and the control; slot contents are not cleared.
// A stalled output holds the update cycle; input stalls just leave the
// block idle.
// ----------------------------------------------------------------------------
module failed_source_lockout_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fslt_pkg::KEY_W-1:0]          source_addr,
  input  logic                                is_failure,
  input  logic [fslt_pkg::TIME_W-1:0]         now_time,
  input  logic                                last_event,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fslt_pkg::OUTCOME_W-1:0]      outcome,
  output logic [fslt_pkg::INDEX_OUT_W-1:0]    entry_index,
  output logic [fslt_pkg::CNT_W-1:0]          fail_total,
  output logic [fslt_pkg::UNIQUE_W-1:0]       unique_count,
  output logic                                last_result,
  input  logic                                cfg_we,
  input  logic [fslt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fslt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  fslt_pkg::state_t state, state_next;

  logic [fslt_pkg::CNT_W-1:0]  lock_limit;
  logic [fslt_pkg::TIME_W-1:0] lock_span;

  logic [fslt_pkg::KEY_W-1:0]  q_addr;
  logic                        q_fail;
  logic [fslt_pkg::TIME_W-1:0] q_now;
  logic                        q_last;
  logic [fslt_pkg::TIME_W-1:0] until_sat;
  logic [fslt_pkg::USED_W-1:0] used, used_next;

  logic in_take;
  logic out_free;
  logic commit;

  fslt_pkg::cell_query_t query;
  fslt_pkg::cell_wr_t    wr;
  fslt_pkg::cell_rd_t    rd;

  logic                        found;
  logic                        has_room;
  logic                        new_entry;
  logic [fslt_pkg::IDX_W-1:0]  slot;
  logic [fslt_pkg::CNT_W-1:0]  cur_cnt;
  logic [fslt_pkg::TIME_W-1:0] cur_until;
  logic                        still_blocked;
  logic [fslt_pkg::CNT_W-1:0]  cnt_inc;
  logic                        reach;
  logic [fslt_pkg::USED_W-1:0] used_after;
  logic [fslt_pkg::OUTCOME_W-1:0] res_outcome;
  logic [fslt_pkg::INDEX_OUT_W-1:0] res_index;
  logic [fslt_pkg::CNT_W-1:0]  res_total;
  logic [fslt_pkg::TIME_W:0]   sum_wide;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_limit <= fslt_pkg::LOCK_LIMIT_RESET;
      lock_span  <= fslt_pkg::LOCK_SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fslt_pkg::REG_LOCK_LIMIT: lock_limit <= cfg_data[fslt_pkg::CNT_W-1:0];
        fslt_pkg::REG_LOCK_SPAN:  lock_span  <= cfg_data[fslt_pkg::TIME_W-1:0];
      endcase
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fslt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      fslt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = fslt_pkg::ST_MATCH;
        end
      end
      fslt_pkg::ST_MATCH: begin
        state_next = fslt_pkg::ST_UPDATE;
      end
      fslt_pkg::ST_UPDATE: begin
        if (out_free) begin
          commit   = 1'b1;
          in_ready = 1'b1;
          state_next = in_valid ? fslt_pkg::ST_MATCH : fslt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fslt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_addr <= source_addr;
      q_fail <= is_failure;
      q_now  <= now_time;
      q_last <= last_event;
    end
  end

  // lockout end time, worked out while the cells compare
  assign sum_wide = {1'b0, q_now} + {1'b0, lock_span};

  always_ff @(posedge clk) begin
    if (state == fslt_pkg::ST_MATCH) begin
      until_sat <= sum_wide[fslt_pkg::TIME_W] ? fslt_pkg::TIME_MAX
                                              : sum_wide[fslt_pkg::TIME_W-1:0];
    end
  end

  assign query.match_en = (state == fslt_pkg::ST_MATCH);
  assign query.key      = q_addr;
  assign query.used     = used;

  fslt_array u_array (
    .clk   (clk),
    .rst   (rst),
    .query (query),
    .wr    (wr),
    .rd    (rd)
  );

  // update of the matching or freshly added slot
  always_comb begin
    found         = rd.hit;
    has_room      = used < fslt_pkg::USED_W'(fslt_pkg::TABLE_ENTRIES);
    new_entry     = q_fail && !found && has_room;
    slot          = found ? rd.idx : used[fslt_pkg::IDX_W-1:0];
    cur_cnt       = found ? rd.count : '0;
    cur_until     = found ? rd.lock_end : '0;
    still_blocked = cur_until > q_now;
    cnt_inc       = (cur_cnt == fslt_pkg::CNT_MAX) ? cur_cnt
                                                   : cur_cnt + fslt_pkg::CNT_W'(1);
    reach         = cnt_inc >= lock_limit;
    used_after    = new_entry ? used + fslt_pkg::USED_W'(1) : used;

    res_outcome = fslt_pkg::OC_IGNORED;
    res_index   = '0;
    res_total   = '0;
    if (q_fail) begin
      if (!found && !has_room) begin
        res_outcome = fslt_pkg::OC_FULL;
      end else if (still_blocked) begin
        res_outcome = fslt_pkg::OC_BLOCKED;
        res_index   = fslt_pkg::INDEX_OUT_W'(slot);
        res_total   = cur_cnt;
      end else begin
        res_outcome = reach ? fslt_pkg::OC_NEW_BLOCK : fslt_pkg::OC_COUNTED;
        res_index   = fslt_pkg::INDEX_OUT_W'(slot);
        res_total   = cnt_inc;
      end
    end

    wr.en       = commit && q_fail && (found || has_room) && !still_blocked;
    wr.idx      = slot;
    wr.key      = q_addr;
    wr.count    = cnt_inc;
    wr.lock_end = reach ? until_sat : cur_until;

    used_next = used;
    if (commit) begin
      used_next = q_last ? '0 : used_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      outcome      <= res_outcome;
      entry_index  <= res_index;
      fail_total   <= res_total;
      unique_count <= fslt_pkg::UNIQUE_W'(used_after);
      last_result  <= q_last;
    end
  end

  a_match_then_update: assert property (@(posedge clk) disable iff (rst)
    state == fslt_pkg::ST_MATCH |=> state == fslt_pkg::ST_UPDATE)
    else $error("compare cycle not followed by update");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    used <= fslt_pkg::USED_W'(fslt_pkg::TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_full_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == fslt_pkg::OC_FULL |-> entry_index == '0 && fail_total == '0)
    else $error("dropped word reports a slot or count");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    commit && q_last |=> used == '0)
    else $error("fill count not cleared at end of batch");

endmodule

### tb/sv/failed_source_lockout_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failed_source_lockout_table_test
// Drives access events into the lockout table with random idling on both
// handshakes. A behavioral copy of the table predicts each result word, and
// every word that leaves the block is compared field by field.
// Threshold and duration move through their extremes between runs.
// ----------------------------------------------------------------------------
module failed_source_lockout_table_test;
  import fslt_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 950;

  typedef struct packed {
    logic [KEY_W-1:0]  addr;
    logic              failed;
    logic [TIME_W-1:0] now;
    logic              last;
  } access_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0]   outcome;
    logic [INDEX_OUT_W-1:0] slot;
    logic [CNT_W-1:0]       total;
    logic [UNIQUE_W-1:0]    uniq;
    logic                   last;
  } verdict_t;

  class lockout_tracker;
    logic [KEY_W-1:0]  keys [TABLE_ENTRIES];
    logic [CNT_W-1:0]  counts [TABLE_ENTRIES];
    logic [TIME_W-1:0] lock_ends [TABLE_ENTRIES];
    int                used;
    logic [CNT_W-1:0]  threshold;
    logic [TIME_W-1:0] duration;
    verdict_t          verdict_q[$];
    int                errors;

    function new();
      used = 0;
      threshold = LOCK_LIMIT_RESET;
      duration = LOCK_SPAN_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOCK_LIMIT: threshold = data[CNT_W-1:0];
        REG_LOCK_SPAN: duration = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // work out the verdict for one accepted access and update the table copy
    function void tally_access(access_t ev);
      verdict_t    v;
      int          slot;
      bit          found;
      logic [32:0] sum;
      v = '0;
      v.last = ev.last;
      if (ev.failed) begin
        found = 0;
        slot = 0;
        for (int j = 0; j < used; j++) begin
          if (!found && keys[j] == ev.addr) begin
            slot = j;
            found = 1;
          end
        end
        if (!found && used < TABLE_ENTRIES) begin
          slot = used;
          used++;
          keys[slot] = ev.addr;
          counts[slot] = '0;
          lock_ends[slot] = '0;
          found = 1;
        end
        if (!found) begin
          v.outcome = OC_FULL;
        end else if (lock_ends[slot] > ev.now) begin
          v.outcome = OC_BLOCKED;
          v.slot = INDEX_OUT_W'(slot);
          v.total = counts[slot];
        end else begin
          if (counts[slot] != CNT_MAX) counts[slot]++;
          v.slot = INDEX_OUT_W'(slot);
          v.total = counts[slot];
          if (counts[slot] >= threshold) begin
            sum = {1'b0, ev.now} + {1'b0, duration};
            lock_ends[slot] = sum[32] ? TIME_MAX : sum[TIME_W-1:0];
            v.outcome = OC_NEW_BLOCK;
          end else begin
            v.outcome = OC_COUNTED;
          end
        end
      end
      v.uniq = used[UNIQUE_W-1:0];
      // end of batch empties the table after reporting
      if (ev.last) used = 0;
      verdict_q.push_back(v);
    endfunction

    function void flag_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = verdict_q.pop_front();
      flag_field("outcome", want.outcome, got.outcome);
      flag_field("entry_index", want.slot, got.slot);
      flag_field("fail_total", want.total, got.total);
      flag_field("unique_count", want.uniq, got.uniq);
      flag_field("last_result", want.last, got.last);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [KEY_W-1:0]       source_addr;
  logic                   is_failure;
  logic [TIME_W-1:0]      now_time;
  logic                   last_event;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUTCOME_W-1:0]   outcome;
  logic [INDEX_OUT_W-1:0] entry_index;
  logic [CNT_W-1:0]       fail_total;
  logic [UNIQUE_W-1:0]    unique_count;
  logic                   last_result;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lockout_tracker book;
  bit             calm;
  int             stall_cycles;
  int             sent;

  failed_source_lockout_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_addr  (source_addr),
    .is_failure   (is_failure),
    .now_time     (now_time),
    .last_event   (last_event),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .entry_index  (entry_index),
    .fail_total   (fail_total),
    .unique_count (unique_count),
    .last_result  (last_result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure unless in a calm stretch
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.match_verdict('{outcome, entry_index, fail_total, unique_count, last_result});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_access(logic [KEY_W-1:0] addr, bit failed, logic [TIME_W-1:0] now,
                             bit last);
    access_t ev;
    ev = '{addr, failed, now, last};
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    source_addr = addr;
    is_failure = failed;
    now_time = now;
    last_event = last;
    do @(posedge clk); while (!in_ready);
    book.tally_access(ev);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    book.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(logic [CNT_W-1:0] thr, logic [TIME_W-1:0] dur);
    drain();
    write_reg(REG_LOCK_LIMIT, CFG_DATA_W'(thr));
    write_reg(REG_LOCK_SPAN, dur);
  endtask

  // one batch of events drawn from a pool of sources, closed by last_event
  task automatic send_batch();
    logic [KEY_W-1:0]  pool[$];
    logic [TIME_W-1:0] now;
    int                pool_size;
    int                len;
    int                step_max;
    bit                crowded;
    logic [KEY_W-1:0]  addr;
    crowded = ($urandom_range(3) == 0);
    pool_size = crowded ? $urandom_range(65, 72) : $urandom_range(1, 10);
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(15))
        0: pool.push_back('0);
        1: pool.push_back('1);
        default: pool.push_back($urandom());
      endcase
    end
    len = crowded ? $urandom_range(90, 130) : $urandom_range(8, 40);
    if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
    case ($urandom_range(3))
      0: now = $urandom();
      1: now = TIME_MAX - $urandom_range(0, 2000);
      default: now = $urandom_range(0, 1000);
    endcase
    step_max = $urandom_range(0, 200);
    for (int i = 0; i < len; i++) begin
      // crowded batches walk the pool first so the table fills up
      addr = (crowded && i < pool_size) ? pool[i] : pool[$urandom_range(pool_size - 1)];
      if ($urandom_range(99) < 3) now = $urandom();
      else now = now + $urandom_range(0, step_max);
      if ($urandom_range(99) < 2) drain();
      send_access(addr, $urandom_range(99) < 88, now,
                  (i == len - 1) || ($urandom_range(99) < 2));
      sent++;
    end
  endtask

  initial begin
    logic [CNT_W-1:0]  thr_set [5] = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd2};
    logic [TIME_W-1:0] dur_set [5] = '{32'd0, 32'hFFFF_FFFF, 32'd300, 32'd300, 32'd50};
    int                phase;
    book = new();
    calm = 1'b0;
    sent = 0;
    stall_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    source_addr = '0;
    is_failure = 1'b0;
    now_time = '0;
    last_event = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limits: count up to a block, stay blocked, then re-block on expiry
    send_access('0, 1'b0, '0, 1'b0);
    repeat (3) send_access('1, 1'b1, '0, 1'b0);
    send_access('1, 1'b1, 32'd299, 1'b0);
    send_access('1, 1'b1, 32'd300, 1'b0);
    send_access('0, 1'b1, 32'd1000, 1'b0);
    send_access(32'h5A5A_A5A5, 1'b0, TIME_MAX, 1'b1);
    send_access('1, 1'b1, TIME_MAX, 1'b0);

    // zero threshold with the longest duration: block end saturates
    set_limits(16'd0, TIME_MAX);
    send_access(32'h1234_5678, 1'b1, 32'd5, 1'b0);
    send_access(32'h1234_5678, 1'b1, TIME_MAX, 1'b0);
    send_access(32'h1234_5678, 1'b1, 32'd100, 1'b1);

    // threshold one, zero duration: a block ends at once
    set_limits(16'd1, 32'd0);
    send_access(32'hDEAD_BEEF, 1'b1, 32'd7, 1'b0);
    send_access(32'hDEAD_BEEF, 1'b1, 32'd7, 1'b0);
    send_access(32'hCAFE_F00D, 1'b1, 32'd8, 1'b1);

    phase = 0;
    while (sent < RANDOM_WORDS) begin
      if (phase < 5) begin
        set_limits(thr_set[phase], dur_set[phase]);
      end else begin
        set_limits(CNT_W'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(1, 6)),
                   ($urandom_range(1) == 0) ? $urandom() : $urandom_range(0, 500));
      end
      calm = (phase == 3);
      repeat ($urandom_range(1, 3)) send_batch();
      phase++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
